// ===== sv/uart_rxbuf_pkg.sv =====
`timescale 1ns / 1ps

package uart_rxbuf_pkg;

    // Operation selector carried on s_tuser
    typedef enum logic [1:0] {
        OP_RX   = 2'd0,
        OP_READ = 2'd1,
        OP_POLL = 2'd2
    } op_t;

    localparam int          BYTE_W     = 8;
    localparam int          OUT_DATA_W = 16;
    localparam logic [7:0]  NOISE_BYTE = 8'h00;

endpackage

// ===== sv/uart_rx_byte_buffer.sv =====
`timescale 1ns / 1ps

// Channel | Dir | Handshake          | Payload
// s_      | in  | s_tvalid/s_tready  | s_tuser = op, s_tdata = rx_byte
// m_      | out | m_tvalid/m_tready  | m_tdata = read_byte, available
//
// One item per cycle unless stalled; one result per item, in the cycle after accept.
// The result is registered: the byte store has a single synchronous read port.
// Reset clears indices, the empty flag and the per-entry valid bits at once;
// an entry never written reads as zero. No clearing pass is needed.
// A stalled result holds in the output register; s_tready drops only while
// that register is full and m_tready is low.

module uart_rx_byte_buffer #(
    parameter int DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic [1:0]  s_tuser,    // [1:0] op

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // [7:0] read_byte, [8] available, [15:9] zero
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(DEPTH);

    logic [uart_rxbuf_pkg::BYTE_W-1:0] store_mem [DEPTH];
    logic [DEPTH-1:0]                  vld_reg;

    logic [IDX_W-1:0] wr_reg, wr_next;
    logic [IDX_W-1:0] rd_reg, rd_next;
    logic             empty_reg, empty_next;
    logic             m_valid_reg;
    logic             avail_reg;
    logic             rsel_reg;
    logic [7:0]       rdata_reg;

    logic             accept;
    logic             we;
    logic [AW-1:0]    waddr;
    logic             rsel;
    logic [IDX_W-1:0] wr_base;
    logic [IDX_W-1:0] rd_inc;
    uart_rxbuf_pkg::op_t op;
    logic [7:0]       read_byte;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign op       = uart_rxbuf_pkg::op_t'(s_tuser);
    assign wr_base  = (wr_reg >= DEPTH_IDX || empty_reg) ? '0 : wr_reg;
    assign rd_inc   = rd_reg + IDX_W'(1);

    always_comb begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        empty_next = empty_reg;
        we         = 1'b0;
        waddr      = wr_base[AW-1:0];
        rsel       = 1'b0;
        unique case (op)
            uart_rxbuf_pkg::OP_RX: begin
                we      = 1'b1;
                wr_next = wr_base;
                // zero byte is line noise: store it, do not advance
                if (s_tdata != uart_rxbuf_pkg::NOISE_BYTE) begin
                    wr_next    = wr_base + IDX_W'(1);
                    empty_next = 1'b0;
                end
            end
            uart_rxbuf_pkg::OP_READ: begin
                priority if (rd_reg >= DEPTH_IDX) begin
                    rd_next    = '0;
                    empty_next = 1'b1;
                end else if (rd_reg >= wr_reg) begin
                    rsel       = 1'b1;
                    rd_next    = '0;
                    wr_next    = '0;
                    empty_next = 1'b1;
                end else if (!empty_reg) begin
                    rsel    = 1'b1;
                    rd_next = rd_inc;
                    if (rd_inc >= DEPTH_IDX) begin
                        rd_next    = '0;
                        empty_next = 1'b1;
                    end
                end else begin
                    rsel = 1'b0;
                end
            end
            uart_rxbuf_pkg::OP_POLL: begin
                if (rd_reg >= wr_reg || rd_reg >= DEPTH_IDX) begin
                    rd_next    = '0;
                    wr_next    = '0;
                    empty_next = 1'b1;
                end
            end
            default: begin
                rsel = 1'b0;
            end
        endcase
    end

    // byte store: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (accept && we) begin
            store_mem[waddr] <= s_tdata;
        end
        if (accept) begin
            rdata_reg <= store_mem[rd_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            wr_reg      <= '0;
            rd_reg      <= '0;
            empty_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept && we) begin
                vld_reg[waddr] <= 1'b1;
            end
            if (accept) begin
                wr_reg    <= wr_next;
                rd_reg    <= rd_next;
                empty_reg <= empty_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload; hold while stalled
    always_ff @(posedge aclk) begin
        if (accept) begin
            rsel_reg  <= rsel && vld_reg[rd_reg[AW-1:0]];
            avail_reg <= !empty_next;
        end
    end

    assign read_byte = rsel_reg ? rdata_reg : uart_rxbuf_pkg::NOISE_BYTE;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {(uart_rxbuf_pkg::OUT_DATA_W - 9)'(0), avail_reg, read_byte};

    a_wr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_reg <= DEPTH_IDX)
        else $error("write index beyond store depth");

    a_rd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_reg < DEPTH_IDX)
        else $error("read index beyond last entry");

    a_avail_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (avail_reg == !empty_reg))
        else $error("available flag disagrees with empty state");

    a_rx_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == uart_rxbuf_pkg::OP_RX && s_tdata != uart_rxbuf_pkg::NOISE_BYTE)
        |=> (!empty_reg && wr_reg != '0))
        else $error("nonzero byte did not fill the buffer");

    a_read_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == uart_rxbuf_pkg::OP_READ && empty_reg && rd_reg < wr_reg)
        |=> (read_byte == uart_rxbuf_pkg::NOISE_BYTE))
        else $error("read from drained buffer returned data");

endmodule
